@@ rtl/tgest_pkg.sv @@
package tgest_pkg;

    // register map, byte address = 4 * index
    localparam int unsigned CFG_ADDR_W = 4;
    localparam logic [1:0]  REG_TAP_TERM     = 2'd0;
    localparam logic [1:0]  REG_CLICK_TERM   = 2'd1;
    localparam logic [1:0]  REG_MOVE_LIMIT   = 2'd2;
    localparam logic [1:0]  REG_RELEASE_TERM = 2'd3;

    localparam logic [15:0] TAP_TERM_RST     = 16'd200;
    localparam logic [15:0] CLICK_TERM_RST   = 16'd20;
    localparam logic [12:0] MOVE_LIMIT_RST   = 13'd48;
    localparam logic [15:0] RELEASE_TERM_RST = 16'd30;

    localparam int unsigned MOVE_W   = 13;
    localparam int unsigned OUT_W    = 8;
    localparam logic [3:0]  CLICKS_MAX = 4'd15;

    typedef struct packed {
        logic [15:0] tap_term;
        logic [15:0] click_term;
        logic [12:0] move_limit;
        logic [15:0] release_term;
    } t_cfg;

    typedef struct packed {
        logic        finger_down;
        logic        finger_was_down;
        logic        touch_moved;
        logic        drag_held;
        logic        click_active;
        logic        click_gap_active;
        logic        drag_candidate;
        logic [1:0]  taps_counted;
        logic [3:0]  clicks_waiting;
        logic [15:0] touch_start_time;
        logic [15:0] last_tap_time;
        logic [15:0] click_phase_time;
        logic [15:0] last_data_time;
    } t_state;

endpackage

@@ rtl/touchpad_tap_gesture_engine_unit.sv @@
// channel   | dir | handshake                  | payload
// ----------+-----+----------------------------+------------------------------------------
// s_axis    | in  | s_axis_tvalid/tready       | one touchpad sample per transfer
// m_axis    | out | m_axis_tvalid/tready       | one result per sample
// apb       | in  | psel, penable, pwrite      | tap/click/move/release terms at 0x0..0xc
//
// every sample passes through the input register, then through the gesture logic into
// the result register; a new sample is taken every cycle unless m_axis back-pressure fills both.
// a result held by a stalled m_axis keeps the next sample parked in the input register,
// so s_axis_tready drops only when both registers are full and m_axis_tready is low.
// synchronous reset clears all gesture state and loads the default terms.
module touchpad_tap_gesture_engine_unit
    import tgest_pkg::*;
#(
    parameter int unsigned POS_BITS = 12,
    parameter int unsigned MAX_TAPS = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // now_ms[15:0], touch_down, pos_x, pos_y, scroll_key, zero fill
    input  logic [((18+2*POS_BITS+7)/8)*8-1:0] s_axis_tdata,
    // sample_valid
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // btn1, freeze_pointer, auto_mouse_hold, zero fill
    output logic [OUT_W-1:0]      m_axis_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int unsigned X_LO = 17;
    localparam int unsigned Y_LO = X_LO + POS_BITS;
    localparam int unsigned SC_B = Y_LO + POS_BITS;

    t_cfg                w_cfg;
    t_state              r_st, n_st;
    logic [POS_BITS-1:0] r_cur_x, r_cur_y, r_start_x, r_start_y;
    logic [POS_BITS-1:0] n_cur_x, n_cur_y, n_start_x, n_start_y;

    logic                r_in_valid;
    logic [15:0]         r_now;
    logic                r_valid, r_touch, r_scroll;
    logic [POS_BITS-1:0] r_pos_x, r_pos_y;

    logic                r_out_valid;
    logic [2:0]          r_out;
    logic                w_btn1, w_freeze, w_hold;
    logic                w_adv, w_fire, w_take;

    tgest_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tgest_step #(
        .POS_BITS (POS_BITS),
        .MAX_TAPS (MAX_TAPS)
    ) u_step (
        .i_now     (r_now),
        .i_valid   (r_valid),
        .i_touch   (r_touch),
        .i_scroll  (r_scroll),
        .i_pos_x   (r_pos_x),
        .i_pos_y   (r_pos_y),
        .i_cfg     (w_cfg),
        .i_st      (r_st),
        .i_cur_x   (r_cur_x),
        .i_cur_y   (r_cur_y),
        .i_start_x (r_start_x),
        .i_start_y (r_start_y),
        .o_st      (n_st),
        .o_cur_x   (n_cur_x),
        .o_cur_y   (n_cur_y),
        .o_start_x (n_start_x),
        .o_start_y (n_start_y),
        .o_btn1    (w_btn1),
        .o_freeze  (w_freeze),
        .o_hold    (w_hold)
    );

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_take        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_W-3){1'b0}}, r_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= '0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_start_x   <= '0;
            r_start_y   <= '0;
        end else begin
            if (w_take) r_in_valid <= 1'b1;
            else if (w_fire) r_in_valid <= 1'b0;

            if (w_fire) r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;

            if (w_fire) begin
                r_st      <= n_st;
                r_cur_x   <= n_cur_x;
                r_cur_y   <= n_cur_y;
                r_start_x <= n_start_x;
                r_start_y <= n_start_y;
            end
        end
    end

    // sample and result payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_now    <= s_axis_tdata[15:0];
            r_touch  <= s_axis_tdata[16];
            r_pos_x  <= s_axis_tdata[X_LO +: POS_BITS];
            r_pos_y  <= s_axis_tdata[Y_LO +: POS_BITS];
            r_scroll <= s_axis_tdata[SC_B];
            r_valid  <= s_axis_tuser;
        end
        if (w_fire) r_out <= {w_hold, w_freeze, w_btn1};
    end

endmodule

@@ rtl/tgest_cfg.sv @@
module tgest_cfg
    import tgest_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic [1:0] w_idx;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[3:2];
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tap_term     <= TAP_TERM_RST;
            r_cfg.click_term   <= CLICK_TERM_RST;
            r_cfg.move_limit   <= MOVE_LIMIT_RST;
            r_cfg.release_term <= RELEASE_TERM_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_TAP_TERM:     r_cfg.tap_term     <= pwdata[15:0];
                REG_CLICK_TERM:   r_cfg.click_term   <= pwdata[15:0];
                REG_MOVE_LIMIT:   r_cfg.move_limit   <= pwdata[12:0];
                REG_RELEASE_TERM: r_cfg.release_term <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_TAP_TERM:     prdata = {16'd0, r_cfg.tap_term};
            REG_CLICK_TERM:   prdata = {16'd0, r_cfg.click_term};
            REG_MOVE_LIMIT:   prdata = {19'd0, r_cfg.move_limit};
            REG_RELEASE_TERM: prdata = {16'd0, r_cfg.release_term};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

@@ rtl/tgest_step.sv @@
module tgest_step
    import tgest_pkg::*;
#(
    parameter int unsigned POS_BITS = 12,
    parameter int unsigned MAX_TAPS = 3
) (
    input  logic [15:0]         i_now,
    input  logic                i_valid,
    input  logic                i_touch,
    input  logic                i_scroll,
    input  logic [POS_BITS-1:0] i_pos_x,
    input  logic [POS_BITS-1:0] i_pos_y,
    input  t_cfg                i_cfg,
    input  t_state              i_st,
    input  logic [POS_BITS-1:0] i_cur_x,
    input  logic [POS_BITS-1:0] i_cur_y,
    input  logic [POS_BITS-1:0] i_start_x,
    input  logic [POS_BITS-1:0] i_start_y,
    output t_state              o_st,
    output logic [POS_BITS-1:0] o_cur_x,
    output logic [POS_BITS-1:0] o_cur_y,
    output logic [POS_BITS-1:0] o_start_x,
    output logic [POS_BITS-1:0] o_start_y,
    output logic                o_btn1,
    output logic                o_freeze,
    output logic                o_hold
);

    localparam logic [1:0] TAPS_LIMIT = 2'(MAX_TAPS);
    localparam int unsigned SUM_W = (POS_BITS + 1 > MOVE_W) ? POS_BITS + 1 : MOVE_W;

    function automatic logic [15:0] f_since(input logic [15:0] now_v, input logic [15:0] stamp);
        return now_v - stamp;
    endfunction

    function automatic t_state f_clear_taps(input t_state s);
        s.taps_counted   = 2'd0;
        s.drag_candidate = 1'b0;
        return s;
    endfunction

    function automatic t_state f_cancel(input t_state s);
        s = f_clear_taps(s);
        s.drag_held        = 1'b0;
        s.click_active     = 1'b0;
        s.click_gap_active = 1'b0;
        s.clicks_waiting   = 4'd0;
        if (s.finger_down) s.touch_moved = 1'b1;
        return s;
    endfunction

    function automatic logic f_idle(input t_state s);
        return !s.click_active && !s.click_gap_active && (s.clicks_waiting == 4'd0);
    endfunction

    function automatic logic f_win_active(input t_state s, input logic [15:0] now_v,
                                          input logic [15:0] term);
        return (s.taps_counted != 2'd0) && (f_since(now_v, s.last_tap_time) <= term);
    endfunction

    function automatic t_state f_start_clicks(input t_state s, input logic [1:0] cnt,
                                              input logic [15:0] now_v);
        logic [4:0] sum;
        sum = {1'b0, s.clicks_waiting} + {3'd0, cnt};
        if (cnt != 2'd0) begin
            if (!f_idle(s)) begin
                s.clicks_waiting = (sum > 5'(CLICKS_MAX)) ? CLICKS_MAX : sum[3:0];
            end else begin
                s.click_active     = 1'b1;
                s.clicks_waiting   = {2'd0, cnt} - 4'd1;
                s.click_phase_time = now_v;
            end
        end
        return s;
    endfunction

    function automatic t_state f_flush(input t_state s, input logic [15:0] now_v);
        logic [1:0] cnt;
        cnt = s.taps_counted;
        s = f_clear_taps(s);
        s = f_start_clicks(s, cnt, now_v);
        return s;
    endfunction

    function automatic t_state f_register_tap(input t_state s, input logic [15:0] now_v,
                                              input logic [15:0] term);
        if (f_win_active(s, now_v, term)) s.taps_counted = s.taps_counted + 2'd1;
        else s.taps_counted = 2'd1;
        s.last_tap_time = now_v;
        if (s.taps_counted >= TAPS_LIMIT) s = f_flush(s, now_v);
        return s;
    endfunction

    t_state              v_s;
    logic [POS_BITS-1:0] v_cx, v_cy, v_sx, v_sy, v_dx, v_dy;
    logic [SUM_W-1:0]    v_msum;
    logic                v_started, v_ended, v_cand, v_btn, v_frozen;

    always_comb begin
        v_s    = i_st;
        v_cx   = i_cur_x;
        v_cy   = i_cur_y;
        v_sx   = i_start_x;
        v_sy   = i_start_y;
        v_cand = 1'b0;

        if (i_scroll) v_s = f_cancel(v_s);

        // fill in a release when the sensor has gone quiet
        if (!i_valid) begin
            if (v_s.finger_down &&
                f_since(i_now, v_s.last_data_time) >= i_cfg.release_term) begin
                v_s.finger_down = 1'b0;
            end
        end else begin
            v_s.last_data_time = i_now;
            v_s.finger_down    = i_touch;
            if (i_touch) begin
                v_cx = i_pos_x;
                v_cy = i_pos_y;
            end
        end

        v_started = v_s.finger_down && !v_s.finger_was_down;
        v_ended   = v_s.finger_was_down && !v_s.finger_down;

        if ((v_s.taps_counted != 2'd0) &&
            (f_since(i_now, v_s.last_tap_time) > i_cfg.tap_term) &&
            (!v_s.finger_down || v_started)) begin
            v_s = f_flush(v_s, i_now);
        end

        if (v_started) begin
            v_cand = f_win_active(v_s, i_now, i_cfg.tap_term);
            v_s.touch_start_time = i_now;
            v_sx = v_cx;
            v_sy = v_cy;
            v_s.touch_moved    = 1'b0;
            v_s.drag_held      = 1'b0;
            v_s.drag_candidate = v_cand;
            if (v_cand) begin
                v_s.click_active     = 1'b0;
                v_s.click_gap_active = 1'b0;
                v_s.clicks_waiting   = 4'd0;
            end else begin
                v_s = f_clear_taps(v_s);
            end
        end

        // manhattan distance from touch start
        v_dx   = (v_cx > v_sx) ? v_cx - v_sx : v_sx - v_cx;
        v_dy   = (v_cy > v_sy) ? v_cy - v_sy : v_sy - v_cy;
        v_msum = SUM_W'(v_dx) + SUM_W'(v_dy);
        if (v_s.finger_down && (v_msum > SUM_W'(i_cfg.move_limit))) v_s.touch_moved = 1'b1;

        if (v_s.drag_candidate && v_s.finger_down &&
            (v_s.touch_moved ||
             f_since(i_now, v_s.touch_start_time) >= i_cfg.tap_term)) begin
            v_s.drag_held = 1'b1;
            v_s = f_clear_taps(v_s);
        end

        if (v_ended) begin
            if (v_s.drag_candidate) begin
                v_s = f_register_tap(v_s, i_now, i_cfg.tap_term);
                v_s.drag_candidate = 1'b0;
            end else if (v_s.drag_held) begin
                v_s = f_clear_taps(v_s);
            end else if (!v_s.touch_moved &&
                         f_since(i_now, v_s.touch_start_time) <= i_cfg.tap_term) begin
                v_s = f_register_tap(v_s, i_now, i_cfg.tap_term);
            end else begin
                v_s = f_clear_taps(v_s);
            end
            v_s.drag_held = 1'b0;
        end

        v_frozen = v_s.finger_down && !v_s.drag_held && !v_s.touch_moved &&
                   (v_s.drag_candidate || f_win_active(v_s, i_now, i_cfg.tap_term) ||
                    f_since(i_now, v_s.touch_start_time) <= i_cfg.tap_term);

        v_btn = v_s.drag_held || v_s.click_active;

        // click train: press phase, then gap phase while clicks remain
        if (v_s.click_active &&
            f_since(i_now, v_s.click_phase_time) >= i_cfg.click_term) begin
            v_s.click_active     = 1'b0;
            v_s.click_phase_time = i_now;
            if (v_s.clicks_waiting != 4'd0) v_s.click_gap_active = 1'b1;
        end else if (v_s.click_gap_active &&
                     f_since(i_now, v_s.click_phase_time) >= i_cfg.click_term) begin
            v_s.click_gap_active = 1'b0;
            v_s.click_active     = 1'b1;
            if (v_s.clicks_waiting != 4'd0) v_s.clicks_waiting = v_s.clicks_waiting - 4'd1;
            v_s.click_phase_time = i_now;
        end

        v_s.finger_was_down = v_s.finger_down;

        if (i_scroll) begin
            v_btn = 1'b0;
            v_s   = f_cancel(v_s);
        end
    end

    assign o_st      = v_s;
    assign o_cur_x   = v_cx;
    assign o_cur_y   = v_cy;
    assign o_start_x = v_sx;
    assign o_start_y = v_sy;
    assign o_btn1    = v_btn;
    assign o_freeze  = v_frozen;
    assign o_hold    = v_s.finger_down || (v_s.taps_counted != 2'd0) || v_s.drag_candidate ||
                       v_s.drag_held || !f_idle(v_s);

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import tgest_pkg::*;

    localparam int POS_BITS = 12;
    localparam int MAX_TAPS = 3;
    localparam int SAMPLE_W = ((18 + 2 * POS_BITS + 7) / 8) * 8;
    localparam int LATENCY  = 2;

    typedef struct {
        bit [15:0] now_ms;
        bit        sample_valid;
        bit        touch_down;
        bit [11:0] pos_x;
        bit [11:0] pos_y;
        bit        scroll_key;
    } touch_sample_t;

    class tap_gesture_tracker;
        bit [15:0] tap_term, click_term, release_term;
        bit [12:0] move_limit;

        bit fdown, fwas, moved, dheld, cact, cgap, dcand, hact;
        bit [1:0]  taps;
        bit [3:0]  waiting;
        bit [15:0] t_start, t_tap, t_phase, t_data, now;
        bit [11:0] sx, sy, cx, cy;

        bit [2:0] button_reports[$];
        int errors;

        function new();
            tap_term     = TAP_TERM_RST;
            click_term   = CLICK_TERM_RST;
            move_limit   = MOVE_LIMIT_RST;
            release_term = RELEASE_TERM_RST;
            {fdown, fwas, moved, dheld, cact, cgap, dcand, hact} = '0;
            taps = '0;
            waiting = '0;
            {t_start, t_tap, t_phase, t_data, now} = '0;
            {sx, sy, cx, cy} = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_TAP_TERM:     tap_term     = value[15:0];
                REG_CLICK_TERM:   click_term   = value[15:0];
                REG_MOVE_LIMIT:   move_limit   = value[12:0];
                REG_RELEASE_TERM: release_term = value[15:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return button_reports.size();
        endfunction

        // wraps modulo 65536
        function bit [15:0] elapsed(bit [15:0] stamp);
            bit [15:0] d;
            d = now - stamp;
            return d;
        endfunction

        function bit window_open();
            return taps != 0 && elapsed(t_tap) <= tap_term;
        endfunction

        function bit window_over();
            return taps != 0 && elapsed(t_tap) > tap_term;
        endfunction

        function bit clicks_idle();
            return !cact && !cgap && waiting == 0;
        endfunction

        function void drop_taps();
            taps  = '0;
            dcand = 1'b0;
        endfunction

        function void cancel_gestures();
            drop_taps();
            dheld   = 1'b0;
            cact    = 1'b0;
            cgap    = 1'b0;
            waiting = '0;
            if (fdown) moved = 1'b1;
        endfunction

        function void refresh_hold();
            hact = fdown || taps != 0 || dcand || dheld || !clicks_idle();
        endfunction

        function void queue_clicks(int count);
            int sum;
            if (count == 0) return;
            if (!clicks_idle()) begin
                sum = int'(waiting) + count;
                waiting = (sum > int'(CLICKS_MAX)) ? CLICKS_MAX : 4'(sum);
                return;
            end
            cact    = 1'b1;
            waiting = 4'(count - 1);
            t_phase = now;
        endfunction

        function void play_taps();
            int count;
            count = taps;
            drop_taps();
            queue_clicks(count);
        endfunction

        function void count_tap();
            taps  = window_open() ? taps + 2'd1 : 2'd1;
            t_tap = now;
            if (taps >= MAX_TAPS) play_taps();
        endfunction

        function int span(bit [11:0] a, bit [11:0] b);
            return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
        endfunction

        function void advance_taps();
            bit started, ended, cand;
            started = fdown && !fwas;
            ended   = fwas && !fdown;
            if (window_over() && (!fdown || started)) play_taps();
            if (started) begin
                cand    = window_open();
                t_start = now;
                sx      = cx;
                sy      = cy;
                moved   = 1'b0;
                dheld   = 1'b0;
                dcand   = cand;
                if (cand) begin
                    cact    = 1'b0;
                    cgap    = 1'b0;
                    waiting = '0;
                end else begin
                    drop_taps();
                end
            end
            if (fdown && span(cx, sx) + span(cy, sy) > int'(move_limit)) moved = 1'b1;
            if (dcand && fdown && (moved || elapsed(t_start) >= tap_term)) begin
                dheld = 1'b1;
                drop_taps();
            end
            if (ended) begin
                if (dcand) begin
                    count_tap();
                    dcand = 1'b0;
                end else if (dheld) begin
                    drop_taps();
                end else if (!moved && elapsed(t_start) <= tap_term) begin
                    count_tap();
                end else begin
                    drop_taps();
                end
                dheld = 1'b0;
            end
            refresh_hold();
        endfunction

        function void advance_clicks();
            if (cact && elapsed(t_phase) >= click_term) begin
                cact    = 1'b0;
                t_phase = now;
                if (waiting != 0) cgap = 1'b1;
            end else if (cgap && elapsed(t_phase) >= click_term) begin
                cgap = 1'b0;
                cact = 1'b1;
                if (waiting != 0) waiting--;
                t_phase = now;
            end
        endfunction

        // returns {auto_mouse_hold, freeze_pointer, btn1}
        function bit [2:0] gesture_step(touch_sample_t s);
            bit frozen, btn;
            now = s.now_ms;
            if (s.scroll_key) begin
                cancel_gestures();
                refresh_hold();
            end
            if (!s.sample_valid) begin
                if (fdown && elapsed(t_data) >= release_term) fdown = 1'b0;
            end else begin
                t_data = now;
                fdown  = s.touch_down;
                if (s.touch_down) begin
                    cx = s.pos_x;
                    cy = s.pos_y;
                end
            end
            advance_taps();
            frozen = fdown && !dheld && !moved &&
                     (dcand || window_open() || elapsed(t_start) <= tap_term);
            btn = dheld || cact;
            advance_clicks();
            refresh_hold();
            fwas = fdown;
            if (s.scroll_key) begin
                btn = 1'b0;
                cancel_gestures();
                refresh_hold();
            end
            return {hact, frozen, btn};
        endfunction

        function void note_sample(touch_sample_t s);
            button_reports.push_back(gesture_step(s));
        endfunction

        function void compare_field(string name, bit want, bit got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_report(logic [OUT_W-1:0] data);
            bit [2:0] want;
            if (button_reports.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, data);
                errors++;
                return;
            end
            want = button_reports.pop_front();
            compare_field("btn1", want[0], data[0]);
            compare_field("freeze_pointer", want[1], data[1]);
            compare_field("auto_mouse_hold", want[2], data[2]);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // now_ms[15:0], touch_down, pos_x, pos_y, scroll_key, zero fill
    logic [SAMPLE_W-1:0]   s_axis_tdata = '0;
    // sample_valid
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // btn1, freeze_pointer, auto_mouse_hold, zero fill
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    tap_gesture_tracker sb;
    bit [15:0] clk_ms = 16'd0;
    int sent = 0;
    int tick = 25;
    int tx_calm = 0;
    int rx_calm = 0;
    int rx_hold = 0;

    touchpad_tap_gesture_engine_unit #(
        .POS_BITS(POS_BITS),
        .MAX_TAPS(MAX_TAPS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        touch_sample_t seen;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                seen.now_ms       = s_axis_tdata[15:0];
                seen.touch_down   = s_axis_tdata[16];
                seen.pos_x        = s_axis_tdata[28:17];
                seen.pos_y        = s_axis_tdata[40:29];
                seen.scroll_key   = s_axis_tdata[41];
                seen.sample_valid = s_axis_tuser;
                sb.note_sample(seen);
            end
            if (m_axis_tvalid && m_axis_tready) sb.check_report(m_axis_tdata);
        end
    end

    // result side back-pressure, with stretches of no stalls
    always @(negedge i_clk) begin
        if (rx_calm > 0) begin
            rx_calm--;
            m_axis_tready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            case ($urandom_range(0, 19))
                0: rx_calm = $urandom_range(20, 200);
                1, 2, 3, 4: rx_hold = $urandom_range(1, 3);
                5: rx_hold = $urandom_range(10, 40);
                default: ;
            endcase
        end
    end

    function automatic int tx_gap();
        if (tx_calm > 0) begin
            tx_calm--;
            return 0;
        end
        case ($urandom_range(0, 19))
            0: begin
                tx_calm = $urandom_range(20, 150);
                return 0;
            end
            1, 2, 3, 4: return $urandom_range(1, 3);
            5: return $urandom_range(10, 40);
            default: return 0;
        endcase
    endfunction

    task automatic put(bit valid, bit touch, bit [11:0] x, bit [11:0] y, bit scroll, int dt);
        int gap;
        gap = tx_gap();
        clk_ms = clk_ms + 16'(dt);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, scroll, y, x, touch, clk_ms};
        s_axis_tuser  <= valid;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_terms(int tap_ms, int click_ms, int move_lim, int release_ms);
        drain();
        write_reg(REG_TAP_TERM, tap_ms);
        write_reg(REG_CLICK_TERM, click_ms);
        write_reg(REG_MOVE_LIMIT, move_lim);
        write_reg(REG_RELEASE_TERM, release_ms);
        tick = tap_ms / 8 + 1;
        if (tick > 8000) tick = 8000;
    endtask

    function automatic bit [11:0] nudge(bit [11:0] p, int r);
        int v;
        v = int'(p) + int'($urandom_range(0, 2 * r)) - r;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return 12'(v);
    endfunction

    task automatic press(bit [11:0] x, bit [11:0] y, int n, int drift, int dt, int scroll_pct);
        bit [11:0] px, py;
        px = x;
        py = y;
        repeat (n) begin
            put(1'b1, 1'b1, px, py, $urandom_range(0, 99) < scroll_pct, $urandom_range(0, dt));
            px = nudge(px, drift);
            py = nudge(py, drift);
        end
    endtask

    task automatic lift(int dt);
        put(1'b1, 1'b0, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), 1'b0, dt);
    endtask

    task automatic tap(bit [11:0] x, bit [11:0] y, int dt, int drift);
        press(x, y, $urandom_range(1, 3), drift, dt, 2);
        lift($urandom_range(0, dt));
    endtask

    task automatic directed_checks();
        clk_ms = 16'hffd0;
        // triple tap across the timestamp wrap, corners of the pad
        put(1, 1, 12'd0, 12'd0, 0, 5);
        put(1, 0, 12'd0, 12'd0, 0, 10);
        put(1, 1, 12'd4095, 12'd4095, 0, 10);
        put(1, 0, 12'd4095, 12'd4095, 0, 10);
        put(1, 1, 12'd4095, 12'd4095, 0, 10);
        put(1, 0, 12'd4095, 12'd4095, 0, 10);
        repeat (3) put(1, 0, 12'd0, 12'd0, 0, 15);
        // tap then hold past the tap term becomes a drag
        put(1, 1, 12'd2048, 12'd2048, 0, 60);
        put(1, 0, 12'd2048, 12'd2048, 0, 5);
        repeat (3) put(1, 1, 12'd2048, 12'd2050, 0, 80);
        put(1, 0, 12'd0, 12'd0, 0, 5);
        // movement beyond the limit is not a tap
        put(1, 1, 12'd100, 12'd100, 0, 300);
        put(1, 1, 12'd200, 12'd200, 0, 5);
        put(1, 0, 12'd0, 12'd0, 0, 5);
        // scroll key during a touch, then plain motion
        put(1, 1, 12'd300, 12'd300, 1, 5);
        put(1, 1, 12'd300, 12'd300, 0, 5);
        put(1, 0, 12'd0, 12'd0, 0, 5);
        // sensor goes quiet, touch released by silence
        put(1, 1, 12'd500, 12'd500, 0, 300);
        put(0, 1, 12'd4095, 12'd4095, 0, 20);
        put(0, 0, 12'd0, 12'd0, 0, 20);
        put(1, 0, 12'd0, 12'd0, 0, 300);
    endtask

    task automatic random_traffic(int target);
        bit [11:0] x, y;
        int short_dt, small_r, big_r;
        while (sent < target) begin
            x        = 12'($urandom_range(0, 4095));
            y        = 12'($urandom_range(0, 4095));
            short_dt = tick / 4 + 1;
            small_r  = sb.move_limit / 6;
            big_r    = sb.move_limit / 2 + 40;
            if (big_r > 2000) big_r = 2000;
            case ($urandom_range(0, 15))
                0, 1, 2, 3: begin
                    tap(x, y, short_dt, small_r);
                    if ($urandom_range(0, 1)) put(1, 0, x, y, 0, $urandom_range(0, tick));
                end
                4: begin
                    // double tap and hold
                    tap(x, y, short_dt, small_r);
                    press(x, y, $urandom_range(8, 16), small_r, 2 * tick, 0);
                    lift(short_dt);
                end
                5: begin
                    // double tap and drag away
                    tap(x, y, short_dt, small_r);
                    press(x, y, $urandom_range(3, 8), big_r, short_dt, 0);
                    lift(short_dt);
                end
                6: begin
                    press(x, y, $urandom_range(3, 12), big_r, tick, 5);
                    lift(short_dt);
                end
                7: repeat ($urandom_range(3, 12)) put(1, 0, x, y, 0, $urandom_range(1, 2 * tick));
                8: begin
                    press(x, y, $urandom_range(1, 3), small_r, short_dt, 0);
                    repeat ($urandom_range(2, 5))
                        put(0, 1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)),
                            12'($urandom_range(0, 4095)), 0,
                            $urandom_range(1, sb.release_term / 2 + 2));
                end
                9: begin
                    press(x, y, $urandom_range(2, 8), small_r, short_dt, 50);
                    lift(short_dt);
                end
                10: begin
                    // rapid triple taps to pile up pending clicks
                    repeat ($urandom_range(3, 6)) begin
                        repeat (3) begin
                            put(1, 1, x, y, 0, $urandom_range(0, 1));
                            put(1, 0, x, y, 0, $urandom_range(0, 1));
                        end
                    end
                end
                11: begin
                    clk_ms = 16'($urandom);
                    put(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), x, y,
                        1'($urandom_range(0, 1)), 0);
                end
                default: begin
                    repeat ($urandom_range(2, 3)) tap(x, y, short_dt, small_r);
                    repeat ($urandom_range(1, 6)) put(1, 0, x, y, 0, $urandom_range(1, tick));
                end
            endcase
        end
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_checks();
        random_traffic(sent + 300);
        set_terms(1, 1, 0, 1);
        random_traffic(sent + 150);
        // zero terms are used as written
        set_terms(0, 0, 0, 0);
        random_traffic(sent + 150);
        set_terms(65535, 65535, 8191, 65535);
        random_traffic(sent + 200);
        set_terms($urandom_range(100, 400), $urandom_range(5, 40),
                  $urandom_range(10, 200), $urandom_range(10, 60));
        random_traffic(sent + 350);
        set_terms(TAP_TERM_RST, CLICK_TERM_RST, MOVE_LIMIT_RST, RELEASE_TERM_RST);
        random_traffic(sent + 300);
        drain();

        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #(8_000_000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
